// ===== design/bitmap_slot_allocator_core_macros.svh =====
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked on the rising clock, off while in reset
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock, off while in reset
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bsa_pkg.sv =====
`timescale 1ns / 1ps

package bsa_pkg;

   localparam int WORD_W  = 32;
   localparam int BIT_W   = 5;
   localparam int SLOT_W  = 8;
   localparam int COUNT_W = 9;

   typedef logic [WORD_W-1:0] word_type;

   typedef logic [1:0] func_type;
   localparam func_type FUNC_ALLOC = 2'd0;
   localparam func_type FUNC_FREE  = 2'd1;
   localparam func_type FUNC_QUERY = 2'd2;
   localparam func_type FUNC_CLEAR = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_FINE  = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_FREED = 2'd3;

   // what the word unit tells the sequencer about the current bitmap word
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] first_bit;
      logic             bit_val;
      logic [BIT_W:0]   free_cnt;
   } scan_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] free_count;
      logic               slot_in_use;
      logic [SLOT_W-1:0]  granted_slot;
      logic               ok;
   } rsp_type;

endpackage

// ===== design/bsa_ram.sv =====
`timescale 1ns / 1ps

module bsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== design/bsa_word_unit.sv =====
`timescale 1ns / 1ps

module bsa_word_unit #(
   parameter int ADDR_W = 3
) (
   input  bsa_pkg::word_type                 word_data,
   input  logic [ADDR_W-1:0]                 word_idx,
   input  logic [bsa_pkg::COUNT_W-1:0]       n_eff,
   input  logic [bsa_pkg::BIT_W-1:0]         bit_sel,
   output bsa_pkg::scan_type                 scan
);

   bsa_pkg::word_type avail;

   // a bit is free for use when it lies below the active count and is clear
   always_comb begin
      for (int b = 0; b < bsa_pkg::WORD_W; b++) begin
         avail[b] = (bsa_pkg::COUNT_W'({word_idx, bsa_pkg::BIT_W'(b)}) < n_eff) &&
                    !word_data[b];
      end
   end

   always_comb begin
      scan.found     = |avail;
      scan.first_bit = '0;
      for (int b = bsa_pkg::WORD_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            scan.first_bit = bsa_pkg::BIT_W'(b);
         end
      end
      scan.bit_val  = word_data[bit_sel];
      scan.free_cnt = (bsa_pkg::BIT_W + 1)'($countones(avail));
   end

endmodule

// ===== design/bitmap_slot_allocator_core.sv =====
`timescale 1ns / 1ps
`include "bitmap_slot_allocator_core_macros.svh"

// Bitmap slot allocator: a used/free bit per slot and a running free count.
// Request channel req_*: tuser carries the operation (allocate, free, query,
// clear), tdata the slot to free or query. One response on rsp_* per request.
// csr_we/csr_wdata set the active slot count; the user must see that it is written
// only while the block is idle, which the block itself does not enforce. The bitmap
// sits in 32-bit words in a small RAM; one word unit (mask, first free bit, bit
// test, free popcount) is reused by a sequencer, one word at a time (RAM read,
// then check and write back). rsp_tvalid rises once the response register is
// loaded: from the emit state for clear, out-of-range and allocate at an active
// count of zero, after a RAM read and check for free and query, and after a read
// and check per scanned word for allocate. One request is in work at a time;
// req_tready comes back in the cycle the response is loaded. A register write
// recounts free slots over the active words, req_tready low meanwhile.
// Reset empties the pool at once through per-word valid bits (no clearing
// pass) and sets the active count to 256. A stalled receiver holds the
// response register; a finished result then waits inside and the block
// accepts nothing until it has been passed on.
module bitmap_slot_allocator_core #(
   parameter int POOL_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] slot_index
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] ok, [8:1] granted_slot, [9] slot_in_use,
                                    // [18:10] free_count, [20:19] status, zero above
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata    // [8:0] active_slots
);

   localparam int MAP_SLOTS = (POOL_SLOTS < 256) ? POOL_SLOTS : 256;
   localparam int NWORDS    = (MAP_SLOTS + bsa_pkg::WORD_W - 1) / bsa_pkg::WORD_W;
   localparam int WADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_CHECK, S_EMIT} state_type;

   state_type                   state_ff, state_in;
   bsa_pkg::func_type           func_ff, func_in;
   logic [7:0]                  idx_ff, idx_in;
   logic [WADDR_W-1:0]          word_ff, word_in;
   logic                        recount_ff, recount_in;
   logic [8:0]                  active_ff, active_in;
   logic [8:0]                  free_ff, free_in;
   logic [NWORDS-1:0]           valid_ff, valid_in;
   bsa_pkg::rsp_type            pend_ff, pend_in;
   bsa_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [8:0]                  n_eff;
   logic [WADDR_W-1:0]          last_word;
   bsa_pkg::word_type           ram_rdata, word_data, ram_wdata, bit_mask;
   logic                        ram_we;
   bsa_pkg::scan_type           scan;

   assign n_eff     = (active_ff > 9'(MAP_SLOTS)) ? 9'(MAP_SLOTS) : active_ff;
   assign last_word = (n_eff == 9'd0) ? '0 : WADDR_W'((n_eff - 9'd1) >> bsa_pkg::BIT_W);
   // a word never written since reset or clear reads as all free
   assign word_data = valid_ff[word_ff] ? ram_rdata : '0;

   bsa_ram #(
      .WIDTH (bsa_pkg::WORD_W),
      .DEPTH (NWORDS)
   ) u_map_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (word_ff),
      .wdata (ram_wdata),
      .raddr (word_ff),
      .rdata (ram_rdata)
   );

   bsa_word_unit #(
      .ADDR_W (WADDR_W)
   ) u_word_unit (
      .word_data (word_data),
      .word_idx  (word_ff),
      .n_eff     (n_eff),
      .bit_sel   (idx_ff[bsa_pkg::BIT_W-1:0]),
      .scan      (scan)
   );

   assign req_tready = (state_ff == S_IDLE) && !csr_we;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff};

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      word_in      = word_ff;
      recount_in   = recount_ff;
      active_in    = csr_we ? csr_wdata : active_ff;
      free_in      = free_ff;
      valid_in     = valid_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_we       = 1'b0;
      bit_mask     = '0;
      ram_wdata    = word_data;

      case (state_ff)
         S_IDLE: begin
            if (csr_we) begin
               // recount free slots below the new active count
               recount_in = 1'b1;
               word_in    = '0;
               free_in    = '0;
               state_in   = S_READ;
            end else if (req_tvalid) begin
               func_in    = req_tuser;
               idx_in     = req_tdata;
               recount_in = 1'b0;
               pend_in    = '0;
               case (req_tuser)
                  bsa_pkg::FUNC_CLEAR: begin
                     valid_in   = '0;
                     free_in    = n_eff;
                     pend_in.ok = 1'b1;
                     state_in   = S_EMIT;
                  end
                  bsa_pkg::FUNC_ALLOC: begin
                     word_in = '0;
                     if (n_eff == 9'd0) begin
                        pend_in.status = bsa_pkg::ST_FULL;
                        state_in       = S_EMIT;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  bsa_pkg::FUNC_FREE, bsa_pkg::FUNC_QUERY: begin
                     word_in = req_tdata[bsa_pkg::BIT_W +: WADDR_W];
                     if (9'(req_tdata) >= n_eff) begin
                        pend_in.status = bsa_pkg::ST_RANGE;
                        state_in       = S_EMIT;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_READ: begin
            state_in = S_CHECK;
         end

         S_CHECK: begin
            if (recount_ff) begin
               free_in = free_ff + 9'(scan.free_cnt);
               if (word_ff == last_word) begin
                  recount_in = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  word_in  = word_ff + 1'b1;
                  state_in = S_READ;
               end
            end else begin
               case (func_ff)
                  bsa_pkg::FUNC_ALLOC: begin
                     if (scan.found) begin
                        bit_mask                = bsa_pkg::word_type'(1) << scan.first_bit;
                        ram_wdata               = word_data | bit_mask;
                        ram_we                  = 1'b1;
                        valid_in[word_ff]       = 1'b1;
                        if (free_ff != 9'd0) begin
                           free_in = free_ff - 9'd1;
                        end
                        pend_in.ok           = 1'b1;
                        pend_in.granted_slot = 8'({word_ff, scan.first_bit});
                        state_in             = S_EMIT;
                     end else if (word_ff == last_word) begin
                        pend_in.status = bsa_pkg::ST_FULL;
                        state_in       = S_EMIT;
                     end else begin
                        word_in  = word_ff + 1'b1;
                        state_in = S_READ;
                     end
                  end
                  bsa_pkg::FUNC_FREE: begin
                     if (!scan.bit_val) begin
                        pend_in.status = bsa_pkg::ST_FREED;
                     end else begin
                        bit_mask          = bsa_pkg::word_type'(1) <<
                                            idx_ff[bsa_pkg::BIT_W-1:0];
                        ram_wdata         = word_data & ~bit_mask;
                        ram_we            = 1'b1;
                        valid_in[word_ff] = 1'b1;
                        if (free_ff < n_eff) begin
                           free_in = free_ff + 9'd1;
                        end
                        pend_in.ok = 1'b1;
                     end
                     state_in = S_EMIT;
                  end
                  bsa_pkg::FUNC_QUERY: begin
                     pend_in.ok          = 1'b1;
                     pend_in.slot_in_use = scan.bit_val;
                     state_in            = S_EMIT;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in            = pend_ff;
               rsp_in.free_count = free_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         recount_ff   <= 1'b0;
         active_ff    <= 9'd256;
         free_ff      <= 9'(MAP_SLOTS);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         recount_ff   <= recount_in;
         active_ff    <= active_in;
         free_ff      <= free_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      idx_ff  <= idx_in;
      word_ff <= word_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   `BSA_ASSERT_NOW(a_ok_matches_status, rsp_tvalid,
      rsp_ff.ok == (rsp_ff.status == bsa_pkg::ST_FINE),
      "response ok flag disagrees with status")

   `BSA_ASSERT_NOW(a_grant_only_on_success, rsp_tvalid && (rsp_ff.granted_slot != 8'd0),
      rsp_ff.ok && (rsp_ff.status == bsa_pkg::ST_FINE),
      "granted slot set on a failed response")

   `BSA_ASSERT_NOW(a_free_within_active, state_ff == S_IDLE,
      free_ff <= n_eff,
      "free count above the active slot count")

   `BSA_ASSERT_NEXT(a_accept_leaves_idle, req_tvalid && req_tready,
      state_ff != S_IDLE,
      "request accepted but sequencer stayed idle")

endmodule

// ===== bench/bsa_response_checker.sv =====
`timescale 1ns / 1ps

module bsa_response_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,
   output int          pending_count,
   output int          error_count
);

   logic [255:0]     slot_taken;
   logic [8:0]       active_cfg;
   logic [8:0]       free_left;
   bsa_pkg::rsp_type awaited_rsp[$];

   // slots usable for allocation, capped at what an 8-bit index can name
   function automatic int unsigned usable_slots();
      return (active_cfg > 9'd256) ? 256 : int'(active_cfg);
   endfunction

   function automatic logic [8:0] count_unused();
      int unsigned n;
      logic [8:0]  c;
      n = usable_slots();
      c = '0;
      for (int i = 0; i < n; i++)
         if (!slot_taken[i]) c++;
      return c;
   endfunction

   function automatic bsa_pkg::rsp_type allocator_step(bsa_pkg::func_type f,
                                                       logic [7:0] s);
      bsa_pkg::rsp_type r;
      int unsigned      n;
      logic             found;
      n = usable_slots();
      r = '0;
      found = 1'b0;
      case (f)
         bsa_pkg::FUNC_ALLOC: begin
            r.status = bsa_pkg::ST_FULL;
            for (int i = 0; i < n; i++) begin
               if (!found && !slot_taken[i]) begin
                  found = 1'b1;
                  slot_taken[i] = 1'b1;
                  if (free_left > 0) free_left--;
                  r.granted_slot = 8'(i);
                  r.ok = 1'b1;
                  r.status = bsa_pkg::ST_FINE;
               end
            end
         end
         bsa_pkg::FUNC_FREE: begin
            if (s >= n) begin
               r.status = bsa_pkg::ST_RANGE;
            end else if (!slot_taken[s]) begin
               r.status = bsa_pkg::ST_FREED;
            end else begin
               slot_taken[s] = 1'b0;
               if (free_left < n) free_left++;
               r.ok = 1'b1;
            end
         end
         bsa_pkg::FUNC_QUERY: begin
            if (s >= n) begin
               r.status = bsa_pkg::ST_RANGE;
            end else begin
               r.slot_in_use = slot_taken[s];
               r.ok = 1'b1;
            end
         end
         default: begin
            slot_taken = '0;
            free_left = 9'(n);
            r.ok = 1'b1;
         end
      endcase
      r.free_count = free_left;
      return r;
   endfunction

   task automatic note_mismatch(input bsa_pkg::rsp_type want, input bsa_pkg::rsp_type got,
                                input logic [2:0] pad);
      if (error_count < 10) begin
         $write("%0t rsp mismatch: ok %0d/%0d grant %0d/%0d in_use %0d/%0d",
                $time, want.ok, got.ok, want.granted_slot, got.granted_slot,
                want.slot_in_use, got.slot_in_use);
         $display(" free %0d/%0d status %0d/%0d pad 0/%0d (exp/act)",
                  want.free_count, got.free_count, want.status, got.status, pad);
      end
      error_count++;
   endtask

   always @(posedge clock) begin : watch
      bsa_pkg::rsp_type got;
      bsa_pkg::rsp_type want;
      if (reset) begin
         slot_taken = '0;
         active_cfg = 9'd256;
         free_left  = 9'd256;
         awaited_rsp.delete();
      end else begin
         if (csr_we) begin
            active_cfg = csr_wdata;
            free_left  = count_unused();
         end
         if (req_tvalid && req_tready)
            awaited_rsp.push_back(allocator_step(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = bsa_pkg::rsp_type'(rsp_tdata[20:0]);
            if (awaited_rsp.size() == 0) begin
               if (error_count < 10)
                  $display("%0t response with no request outstanding: %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (got !== want || rsp_tdata[23:21] !== 3'b000)
                  note_mismatch(want, got, rsp_tdata[23:21]);
            end
         end
      end
      pending_count = awaited_rsp.size();
   end

endmodule

// ===== bench/bitmap_slot_allocator_core_tb.sv =====
`timescale 1ns / 1ps

module bitmap_slot_allocator_core_tb;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int          RX_HOLD_CYCLES = 300;
   localparam int          ITEMS_PER_SET  = 50;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [8:0]  csr_wdata = '0;

   int          pending_count;
   int          error_count;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          active_now = 256;
   logic        hold_rsp = 1'b0;
   int unsigned cycle_count = 0;
   event        rx_hold_start;

   always #5 clock = ~clock;

   bitmap_slot_allocator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   bsa_response_checker rsp_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bitmap_slot_allocator_core_tb failed");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= rx_idle_pct);

   // long receiver stall so the response register backs up into the request side
   initial begin
      @(rx_hold_start);
      @(negedge clock);
      hold_rsp <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic push_request(input bsa_pkg::func_type f, input logic [7:0] s);
      @(negedge clock);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_active(input logic [8:0] v);
      drain_requests();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      active_now = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_request();
      int                n;
      int                r;
      int                k;
      bsa_pkg::func_type f;
      logic [7:0]        s;
      n = (active_now > 256) ? 256 : active_now;
      r = $urandom_range(99);
      if (r < 45)      f = bsa_pkg::FUNC_ALLOC;
      else if (r < 75) f = bsa_pkg::FUNC_FREE;
      else if (r < 97) f = bsa_pkg::FUNC_QUERY;
      else             f = bsa_pkg::FUNC_CLEAR;
      // mostly aim at the low slots, where allocations pile up
      k = $urandom_range(99);
      if (n > 0 && k < 70)      s = 8'($urandom_range(0, (n - 1 < 47) ? n - 1 : 47));
      else if (n > 0 && k < 90) s = 8'($urandom_range(0, n - 1));
      else                      s = 8'($urandom_range(0, 255));
      push_request(f, s);
   endtask

   function automatic logic [8:0] pick_active();
      case ($urandom_range(0, 9))
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'd256;
         3:       return 9'd511;
         4, 5, 6: return 9'($urandom_range(2, 24));
         default: return 9'($urandom_range(25, 300));
      endcase
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full pool after reset
      push_request(bsa_pkg::FUNC_QUERY, 8'd0);
      push_request(bsa_pkg::FUNC_QUERY, 8'd255);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd255);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);
      push_request(bsa_pkg::FUNC_FREE, 8'd1);
      push_request(bsa_pkg::FUNC_FREE, 8'd1);
      push_request(bsa_pkg::FUNC_FREE, 8'd255);
      push_request(bsa_pkg::FUNC_QUERY, 8'd0);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);
      push_request(bsa_pkg::FUNC_CLEAR, 8'd255);
      push_request(bsa_pkg::FUNC_QUERY, 8'd2);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);

      // shrink below an allocated slot: it stays marked
      write_active(9'd2);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);
      push_request(bsa_pkg::FUNC_FREE, 8'd2);
      push_request(bsa_pkg::FUNC_QUERY, 8'd200);
      push_request(bsa_pkg::FUNC_FREE, 8'd0);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);

      // above the pool size, saturates
      write_active(9'd511);
      push_request(bsa_pkg::FUNC_QUERY, 8'd2);

      write_active(9'd0);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);
      push_request(bsa_pkg::FUNC_FREE, 8'd0);
      push_request(bsa_pkg::FUNC_QUERY, 8'd255);
      push_request(bsa_pkg::FUNC_CLEAR, 8'd0);

      write_active(9'd1);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);
      push_request(bsa_pkg::FUNC_ALLOC, 8'd0);

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin tx_idle_pct = 28; rx_idle_pct = 80; end
            1: begin tx_idle_pct = 80; rx_idle_pct = 28; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (int set = 0; set < 4; set++) begin
            write_active(pick_active());
            if (ph == 2 && set == 1) -> rx_hold_start;
            repeat (ITEMS_PER_SET) random_request();
         end
      end

      drain_requests();
      if (error_count == 0 && pending_count == 0)
         $display("bitmap_slot_allocator_core_tb passed");
      else
         $display("bitmap_slot_allocator_core_tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/bsa_pkg.sv
design/bsa_ram.sv
design/bsa_word_unit.sv
design/bitmap_slot_allocator_core.sv
bench/bsa_response_checker.sv
bench/bitmap_slot_allocator_core_tb.sv
